/* design/assert_macros.svh */
// Assertion shorthands used by the address generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle, outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

/* design/dpag_pkg.sv */
`timescale 1ns / 1ps

package dpag_pkg;

   localparam int MAX_DIMS       = 4;
   localparam int DIM_IDX_BITS   = $clog2(MAX_DIMS);
   localparam int EXTENT_BITS    = 12;
   localparam int EXT_REG_BITS   = EXTENT_BITS + 1;
   localparam int BYTES_BITS     = 4;
   localparam int ORDER_BITS     = MAX_DIMS * DIM_IDX_BITS;
   localparam int OFFSET_BITS    = 51;
   localparam int LENGTH_BITS    = 52;
   localparam int LEVEL_BITS     = 3;
   localparam int MUL_B_BITS     = EXT_REG_BITS;
   localparam int MUL_STEP_BITS  = 4;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 160;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - 2 * OFFSET_BITS - LENGTH_BITS;

   localparam logic [EXT_REG_BITS-1:0] EXTENT_CAP = EXT_REG_BITS'(1 << EXTENT_BITS);
   localparam logic [BYTES_BITS-1:0]   BYTES_CAP  = BYTES_BITS'(8);
   localparam logic [ORDER_BITS-1:0]   ORDER_IDENTITY = ORDER_BITS'(228);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EXTENT_DIM0   = 3'd0,
      CSR_EXTENT_DIM1   = 3'd1,
      CSR_EXTENT_DIM2   = 3'd2,
      CSR_EXTENT_DIM3   = 3'd3,
      CSR_ELEMENT_BYTES = 3'd4,
      CSR_OUTPUT_ORDER  = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      SU_IDLE,
      SU_START,
      SU_STRIDE,
      SU_DELTA_INIT,
      SU_DELTA
   } setup_state_type;

   typedef struct packed {
      logic                                   busy;
      logic                                   clear;
      logic                                   order_error;
      logic [MAX_DIMS-1:0]                    level_on;
      logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]   odm1;
      logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]   delta;
      logic [LENGTH_BITS-1:0]                 length;
   } dpag_cfg_type;

   function automatic logic [EXT_REG_BITS-1:0] clamp_extent(input logic [EXT_REG_BITS-1:0] e);
      logic [EXT_REG_BITS-1:0] r;
      r = e;
      if (e == '0) r = EXT_REG_BITS'(1);
      else if (e > EXTENT_CAP) r = EXTENT_CAP;
      return r;
   endfunction

   function automatic logic [BYTES_BITS-1:0] clamp_bytes(input logic [BYTES_BITS-1:0] b);
      logic [BYTES_BITS-1:0] r;
      r = b;
      if (b == '0) r = BYTES_BITS'(1);
      else if (b > BYTES_CAP) r = BYTES_CAP;
      return r;
   endfunction

endpackage

/* design/dpag_setup.sv */
`timescale 1ns / 1ps

module dpag_setup (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dpag_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output dpag_pkg::dpag_cfg_type                cfg
);
   import dpag_pkg::*;

   logic [MAX_DIMS-1:0][EXT_REG_BITS-1:0] extent_ff, extent_in;
   logic [BYTES_BITS-1:0]                 bytes_ff, bytes_in;
   logic [ORDER_BITS-1:0]                 order_ff, order_in;

   setup_state_type                       state_ff, state_in;
   logic [LEVEL_BITS-1:0]                 idx_ff, idx_in;
   logic [MUL_STEP_BITS-1:0]              bit_ff, bit_in;
   logic [LENGTH_BITS-1:0]                mul_a_ff, mul_a_in;
   logic [MUL_B_BITS-1:0]                 mul_b_ff, mul_b_in;
   logic [LENGTH_BITS-1:0]                mul_p_ff, mul_p_in;
   logic [MAX_DIMS-1:0][LENGTH_BITS-1:0]  istr_ff, istr_in;
   logic [LENGTH_BITS-1:0]                len_ff, len_in;
   logic [MAX_DIMS-1:0][OFFSET_BITS-1:0]  delta_ff, delta_in;
   logic [OFFSET_BITS-1:0]                wsum_ff, wsum_in;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  odm1_ff, odm1_in;

   logic [MAX_DIMS-1:0][DIM_IDX_BITS-1:0] sel;
   logic [MAX_DIMS-1:0][EXT_REG_BITS-1:0] idim;
   logic [BYTES_BITS-1:0]                 eb;
   logic                                  dup;
   logic [LEVEL_BITS-1:0]                 keep;
   logic                                  lead;
   logic [LEVEL_BITS:0]                   pos;
   logic                                  pos_on;
   logic [DIM_IDX_BITS-1:0]               src_dim;
   logic [EXTENT_BITS-1:0]                odm1_val;
   logic [LENGTH_BITS-1:0]                mul_sum;
   logic                                  mul_last;
   logic                                  csr_hit;

   assign csr_ready = 1'b1;

   always_comb begin
      dup  = 1'b0;
      keep = '0;
      lead = 1'b1;
      for (int j = 0; j < MAX_DIMS; j++) begin
         sel[j]  = order_ff[DIM_IDX_BITS*j +: DIM_IDX_BITS];
         idim[j] = clamp_extent(extent_ff[j]);
      end
      for (int i = 0; i < MAX_DIMS; i++) begin
         for (int j = i + 1; j < MAX_DIMS; j++) begin
            if (sel[i] == sel[j]) dup = 1'b1;
         end
         if (lead && sel[i] == DIM_IDX_BITS'(i)) keep = keep + LEVEL_BITS'(1);
         else lead = 1'b0;
      end
      eb       = clamp_bytes(bytes_ff);
      pos      = {1'b0, idx_ff} + {1'b0, keep};
      pos_on   = pos < (LEVEL_BITS + 1)'(MAX_DIMS);
      src_dim  = sel[pos[DIM_IDX_BITS-1:0]];
      odm1_val = EXTENT_BITS'(idim[src_dim] - EXT_REG_BITS'(1));
      mul_sum  = mul_p_ff + (mul_b_ff[0] ? mul_a_ff : '0);
      mul_last = bit_ff == MUL_STEP_BITS'(MUL_B_BITS - 1);
   end

   always_comb begin
      extent_in = extent_ff;
      bytes_in  = bytes_ff;
      order_in  = order_ff;
      state_in  = state_ff;
      idx_in    = idx_ff;
      bit_in    = bit_ff;
      mul_a_in  = mul_a_ff;
      mul_b_in  = mul_b_ff;
      mul_p_in  = mul_p_ff;
      istr_in   = istr_ff;
      len_in    = len_ff;
      delta_in  = delta_ff;
      wsum_in   = wsum_ff;
      odm1_in   = odm1_ff;
      csr_hit   = 1'b0;

      unique case (state_ff)
         SU_IDLE: begin
         end
         SU_START: begin
            istr_in[0] = LENGTH_BITS'(eb);
            if (keep == '0) len_in = LENGTH_BITS'(eb);
            mul_a_in = LENGTH_BITS'(eb);
            mul_b_in = idim[0];
            mul_p_in = '0;
            bit_in   = '0;
            idx_in   = LEVEL_BITS'(1);
            state_in = SU_STRIDE;
         end
         SU_STRIDE: begin
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            mul_p_in = mul_sum;
            bit_in   = bit_ff + MUL_STEP_BITS'(1);
            if (mul_last) begin
               if (keep == idx_ff) len_in = mul_sum;
               if (idx_ff == LEVEL_BITS'(MAX_DIMS)) begin
                  idx_in   = '0;
                  wsum_in  = '0;
                  state_in = SU_DELTA_INIT;
               end else begin
                  istr_in[idx_ff[DIM_IDX_BITS-1:0]] = mul_sum;
                  mul_a_in = mul_sum;
                  mul_b_in = idim[idx_ff[DIM_IDX_BITS-1:0]];
                  mul_p_in = '0;
                  bit_in   = '0;
                  idx_in   = idx_ff + LEVEL_BITS'(1);
               end
            end
         end
         SU_DELTA_INIT: begin
            if (pos_on) begin
               delta_in[idx_ff[DIM_IDX_BITS-1:0]] =
                  istr_ff[src_dim][OFFSET_BITS-1:0] - wsum_ff;
               odm1_in[idx_ff[DIM_IDX_BITS-1:0]] = odm1_val;
               mul_a_in = istr_ff[src_dim];
               mul_b_in = MUL_B_BITS'(odm1_val);
               mul_p_in = '0;
               bit_in   = '0;
               state_in = SU_DELTA;
            end else begin
               state_in = SU_IDLE;
            end
         end
         SU_DELTA: begin
            mul_a_in = mul_a_ff << 1;
            mul_b_in = mul_b_ff >> 1;
            mul_p_in = mul_sum;
            bit_in   = bit_ff + MUL_STEP_BITS'(1);
            if (mul_last) begin
               wsum_in = wsum_ff + mul_sum[OFFSET_BITS-1:0];
               if (idx_ff == LEVEL_BITS'(MAX_DIMS - 1)) begin
                  state_in = SU_IDLE;
               end else begin
                  idx_in   = idx_ff + LEVEL_BITS'(1);
                  state_in = SU_DELTA_INIT;
               end
            end
         end
         default: begin
            state_in = SU_START;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_EXTENT_DIM0, CSR_EXTENT_DIM1, CSR_EXTENT_DIM2, CSR_EXTENT_DIM3: begin
               extent_in[csr_index[DIM_IDX_BITS-1:0]] = csr_data[EXT_REG_BITS-1:0];
               csr_hit = 1'b1;
            end
            CSR_ELEMENT_BYTES: begin
               bytes_in = csr_data[BYTES_BITS-1:0];
               csr_hit  = 1'b1;
            end
            CSR_OUTPUT_ORDER: begin
               order_in = csr_data[ORDER_BITS-1:0];
               csr_hit  = 1'b1;
            end
            default: begin
            end
         endcase
         if (csr_hit) state_in = SU_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_DIMS; j++) extent_ff[j] <= EXT_REG_BITS'(1);
         bytes_ff <= BYTES_BITS'(1);
         order_ff <= ORDER_IDENTITY;
         state_ff <= SU_START;
         idx_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         extent_ff <= extent_in;
         bytes_ff  <= bytes_in;
         order_ff  <= order_in;
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         bit_ff    <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      mul_p_ff <= mul_p_in;
      istr_ff  <= istr_in;
      len_ff   <= len_in;
      delta_ff <= delta_in;
      wsum_ff  <= wsum_in;
      odm1_ff  <= odm1_in;
   end

   always_comb begin
      cfg.busy        = state_ff != SU_IDLE;
      cfg.clear       = csr_hit;
      cfg.order_error = dup;
      for (int c = 0; c < MAX_DIMS; c++) begin
         cfg.level_on[c] = ((LEVEL_BITS + 1)'(c) + {1'b0, keep}) < (LEVEL_BITS + 1)'(MAX_DIMS);
      end
      cfg.odm1   = odm1_ff;
      cfg.delta  = delta_ff;
      cfg.length = len_ff;
   end

endmodule

/* design/dimension_permute_addr_gen.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// req     | in        | req_tvalid/req_tready | req_tdata: restart
// rsp     | out       | rsp_tvalid/rsp_tready | rsp_tdata, rsp_tlast, rsp_tuser
// csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One item is accepted per cycle outside setup and stalls; its descriptor is registered.
// Offsets advance by stored per-level increments, so no multiply sits in the item path.
// After reset and after every register write, a bit-serial stride setup runs while
// req_tready stays low.
// The input is also held off in the cycle of a register write.
// A stalled result holds the output register and stops input until it is taken.
`include "assert_macros.svh"

module dimension_permute_addr_gen (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [dpag_pkg::REQ_DATA_BITS-1:0]    req_tdata,  // restart, zero padding
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [dpag_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,  // source_offset, dest_offset,
                                                             // copy_length, zero padding
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,  // order_error
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dpag_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [dpag_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import dpag_pkg::*;

   dpag_cfg_type                          cfg;

   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  cnt_ff, cnt_in;
   logic [OFFSET_BITS-1:0]                src_ff, src_in;
   logic [OFFSET_BITS-1:0]                dst_ff, dst_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0]              rsp_data_ff, rsp_data_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic                                  rsp_err_ff, rsp_err_in;

   logic                                  req_fire;
   logic                                  restart;
   logic [MAX_DIMS-1:0][EXTENT_BITS-1:0]  cnt_eff;
   logic [OFFSET_BITS-1:0]                src_eff;
   logic [OFFSET_BITS-1:0]                dst_eff;
   logic [MAX_DIMS-1:0]                   at_max;
   logic                                  all_max;
   logic                                  found;
   logic [DIM_IDX_BITS-1:0]               step_lvl;
   logic                                  cnt_in_range;

   dpag_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req_tready = !cfg.busy && !cfg.clear && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign restart    = req_tdata[0];

   always_comb begin
      found    = 1'b0;
      step_lvl = '0;
      src_eff  = restart ? '0 : src_ff;
      dst_eff  = restart ? '0 : dst_ff;
      for (int c = 0; c < MAX_DIMS; c++) begin
         cnt_eff[c] = restart ? '0 : cnt_ff[c];
         at_max[c]  = !cfg.level_on[c] || cnt_eff[c] == cfg.odm1[c];
         if (!found && !at_max[c]) begin
            step_lvl = DIM_IDX_BITS'(c);
            found    = 1'b1;
         end
      end
      all_max = &at_max;

      cnt_in       = cnt_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (cfg.clear) begin
         cnt_in = '0;
         src_in = '0;
         dst_in = '0;
      end else if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (cfg.order_error) begin
            cnt_in      = '0;
            src_in      = '0;
            dst_in      = '0;
            rsp_data_in = '0;
            rsp_last_in = 1'b1;
            rsp_err_in  = 1'b1;
         end else begin
            for (int c = 0; c < MAX_DIMS; c++) begin
               if (all_max || DIM_IDX_BITS'(c) < step_lvl) cnt_in[c] = '0;
               else if (DIM_IDX_BITS'(c) == step_lvl) cnt_in[c] = cnt_eff[c] + EXTENT_BITS'(1);
               else cnt_in[c] = cnt_eff[c];
            end
            src_in      = all_max ? '0 : src_eff + cfg.delta[step_lvl];
            dst_in      = all_max ? '0 : dst_eff + cfg.length[OFFSET_BITS-1:0];
            rsp_data_in = {{RSP_PAD_BITS{1'b0}}, cfg.length, dst_eff, src_eff};
            rsp_last_in = all_max;
            rsp_err_in  = 1'b0;
         end
      end
   end

   always_comb begin
      cnt_in_range = 1'b1;
      for (int c = 0; c < MAX_DIMS; c++) begin
         if (cfg.level_on[c] && cnt_ff[c] > cfg.odm1[c]) cnt_in_range = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   `ASSERT_IMPLY(a_no_item_during_setup, clock, reset, req_tvalid && req_tready, !cfg.busy, "item accepted while stride setup runs")
   `ASSERT_RST(a_restart_zero_offsets, clock, reset, (req_tvalid && req_tready && req_tdata[0] && !cfg.clear) |=> (rsp_tvalid && rsp_tdata[2*OFFSET_BITS-1:0] == '0), "restart item did not start at offset zero")
   `ASSERT_IMPLY(a_counters_in_range, clock, reset, !cfg.busy, cnt_in_range, "position counter beyond its extent")

endmodule
